@@ sv/fpsqrt_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsqrt_pkg
// shared widths, stage payload type and first-guess function
// ----------------------------------------------------------------------------
`default_nettype none

package fpsqrt_pkg;

  localparam int unsigned XW      = 16;
  localparam int unsigned RW      = 10;
  localparam int unsigned GW      = 15;
  localparam int unsigned NW      = 19;
  localparam int unsigned FRAC    = 4;
  localparam logic [RW-1:0] RootMax = '1;

  typedef struct packed {
    logic          pos;
    logic [GW-1:0] x;
    logic [GW-1:0] g;
    logic          done;
  } it_t;

  function automatic logic [GW-1:0] first_guess(input logic [GW-1:0] x);
    logic [GW-1:0] r;
    if (x >= GW'(64 << FRAC)) begin
      r = x >> 3;
    end else if (x >= GW'(16 << FRAC)) begin
      r = x >> 2;
    end else if (x >= GW'(4 << FRAC)) begin
      r = x >> 1;
    end else if (x >= GW'(1 << FRAC)) begin
      r = x;
    end else begin
      r = GW'(1 << FRAC);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/fpsqrt_div.sv @@
// ----------------------------------------------------------------------------
// fpsqrt_div
// pipelined restoring divider, one quotient bit per stage, carries the item
// ----------------------------------------------------------------------------
`default_nettype none

module fpsqrt_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  fpsqrt_pkg::it_t     it_i,
  output logic                valid_o,
  output fpsqrt_pkg::it_t     it_o,
  output logic [fpsqrt_pkg::NW-1:0] quo_o
);
  import fpsqrt_pkg::*;

  localparam int unsigned S = NW;

  logic [S:0]           v_q;
  it_t                  it_q  [S+1];
  logic [NW-1:0]        num_q [S+1];
  logic [GW:0]          rem_q [S+1];
  logic [NW-1:0]        quo_q [S+1];

  always_comb begin
    v_q[0]   = valid_i;
    it_q[0]  = it_i;
    num_q[0] = {it_i.x, {FRAC{1'b0}}};
    rem_q[0] = '0;
    quo_q[0] = '0;
  end

  for (genvar k = 0; k < S; k++) begin : g_st
    logic [GW+1:0] sh;
    logic [GW+1:0] df;
    always_comb begin
      sh = {rem_q[k], num_q[k][NW-1]};
      df = sh - {2'b00, it_q[k].g};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[k+1]  <= it_q[k];
        num_q[k+1] <= num_q[k] << 1;
        if (!df[GW+1]) begin
          rem_q[k+1] <= df[GW:0];
          quo_q[k+1] <= {quo_q[k][NW-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= sh[GW:0];
          quo_q[k+1] <= {quo_q[k][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[S];
  assign it_o    = it_q[S];
  assign quo_o   = (it_q[S].g == '0) ? '0 : quo_q[S];

endmodule

`default_nettype wire

@@ sv/fpsqrt_iter.sv @@
// ----------------------------------------------------------------------------
// fpsqrt_iter
// one newton step: divide pipeline then average, early-stop flag kept
// ----------------------------------------------------------------------------
`default_nettype none

module fpsqrt_iter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fpsqrt_pkg::it_t it_i,
  output logic            valid_o,
  output fpsqrt_pkg::it_t it_o
);
  import fpsqrt_pkg::*;

  logic            dv;
  it_t             dit;
  logic [NW-1:0]   quo;
  logic [NW:0]     sum;
  logic [GW-1:0]   nxt;
  logic            v_q;
  it_t             it_q;

  fpsqrt_div u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i (valid_i),
    .it_i    (it_i),
    .valid_o (dv),
    .it_o    (dit),
    .quo_o   (quo)
  );

  always_comb begin
    sum = {{(NW-GW+1){1'b0}}, dit.g} + {1'b0, quo};
    nxt = GW'(sum >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_q <= dit;
      if (!dit.done) begin
        if (nxt == dit.g) begin
          it_q.done <= 1'b1;
        end else begin
          it_q.g <= nxt;
        end
      end
    end
  end

  assign valid_o = v_q;
  assign it_o    = it_q;

endmodule

`default_nettype wire

@@ sv/fixed_point_sqrt_newton.sv @@
// ----------------------------------------------------------------------------
// fixed_point_sqrt_newton
// 12.4 fixed-point square root by newton iteration, fully pipelined
// ----------------------------------------------------------------------------
// One beat enters per cycle while the pipe advances: each newton step is a
// 19-stage restoring divider, one quotient bit per stage, followed by an
// averaging stage; one more register holds the first guess and one the
// saturated result. The whole pipe advances when the output register is
// empty or being taken.
`default_nettype none

module fixed_point_sqrt_newton #(
  parameter int unsigned MAX_ITERATIONS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [15:0]      x_raw_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [9:0]              root_raw_o
);
  import fpsqrt_pkg::*;

  logic            en;
  logic            v_q;
  it_t             it_q;
  logic            sv [MAX_ITERATIONS+1];
  it_t             sit [MAX_ITERATIONS+1];
  logic            ov_q;
  logic [RW-1:0]   root_q;
  logic [GW-1:0]   g;

  assign en      = !ov_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_q.pos  <= (x_raw_i != '0) && !x_raw_i[XW-1];
      it_q.x    <= x_raw_i[GW-1:0];
      it_q.g    <= first_guess(x_raw_i[GW-1:0]);
      it_q.done <= 1'b0;
    end
  end

  assign sv[0]  = v_q;
  assign sit[0] = it_q;

  for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_it
    fpsqrt_iter u_it (
      .clk_i, .rst_ni,
      .en_i    (en),
      .valid_i (sv[i]),
      .it_i    (sit[i]),
      .valid_o (sv[i+1]),
      .it_o    (sit[i+1])
    );
  end

  assign g = sit[MAX_ITERATIONS].g;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= sv[MAX_ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!sit[MAX_ITERATIONS].pos) begin
        root_q <= '0;
      end else if (g > GW'(RootMax)) begin
        root_q <= RootMax;
      end else begin
        root_q <= g[RW-1:0];
      end
    end
  end

  assign valid_o    = ov_q;
  assign root_raw_o = root_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !ready_i |=> ov_q && $stable(root_q))
    else $error("held result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o == (!valid_o || ready_i))
    else $error("ready does not follow output stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && valid_i |=> v_q)
    else $error("accepted beat lost at entry");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the newton square root pipe against a bit-exact software predictor,
// with directed corner operands, random operands and random stalls on both
// sides of the handshake
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpsqrt_pkg::*;

  localparam int NumIter   = 6;
  localparam int WdogLimit = 20000;
  localparam int MaxShown  = 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               ready_o;
  logic signed [15:0] x_raw_i = '0;
  logic               valid_o;
  logic               ready_i = 1'b0;
  logic [9:0]         root_raw_o;

  logic [RW-1:0] root_q[$];
  int            n_bad = 0;
  int            send_idle = 0;
  int            recv_stall = 0;
  int            wdog = 0;

  always #5 clk_i = ~clk_i;

  fixed_point_sqrt_newton #(.MAX_ITERATIONS(NumIter)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .ready_o(ready_o),
    .x_raw_i(x_raw_i), .valid_o(valid_o), .ready_i(ready_i),
    .root_raw_o(root_raw_o)
  );

  function automatic logic [RW-1:0] sqrt_root(input logic [15:0] xr);
    logic [31:0] x, g, q, nx;
    if (xr == '0 || xr[15]) return '0;
    x = {16'b0, xr};
    if (x >= (64 << 4)) g = x >> 3;
    else if (x >= (16 << 4)) g = x >> 2;
    else if (x >= (4 << 4)) g = x >> 1;
    else if (x >= (1 << 4)) g = x;
    else g = 16;
    for (int i = 0; i < NumIter; i++) begin
      q = (g == 0) ? 0 : (x << 4) / g;
      nx = (g + q) >> 1;
      if (nx == g) break;
      g = nx;
    end
    if (g > 1023) g = 1023;
    return g[RW-1:0];
  endfunction

  // receiver side stalls and result checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        if (root_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MaxShown) $display("unexpected beat root=%0d", root_raw_o);
        end else begin
          if (root_raw_o !== root_q[0]) begin
            n_bad++;
            if (n_bad <= MaxShown)
              $display("root mismatch exp=%0d act=%0d", root_q[0], root_raw_o);
          end
          void'(root_q.pop_front());
        end
      end
      ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_x(input logic [15:0] xv);
    while ($urandom_range(99) < send_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    x_raw_i <= xv;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    root_q.push_back(sqrt_root(xv));
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (root_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corners();
    logic [15:0] vals[] = '{16'h0000, 16'h0001, 16'h000f, 16'h0010, 16'h0011,
      16'h003f, 16'h0040, 16'h00ff, 16'h0100, 16'h03ff, 16'h0400, 16'h0401,
      16'h7fff, 16'h7ffe, 16'h8000, 16'hffff, 16'h5555, 16'h2aaa, 16'h0002};
    foreach (vals[i]) send_x(vals[i]);
  endtask

  task automatic test_random(input int n, input int si, input int rs);
    send_idle = si;
    recv_stall = rs;
    repeat (n) begin
      case ($urandom_range(3))
        0: send_x(16'($urandom_range(16'h0000, 16'h0080)));
        1: send_x(16'($urandom_range(16'h0000, 16'h1000)));
        default: send_x(16'($urandom));
      endcase
    end
  endtask

  task automatic test_pause();
    send_x(16'($urandom_range(1, 16'h7fff)));
    drain();
    send_x(16'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_random(320, 0, 0);
    test_random(320, 56, 0);
    test_pause();
    test_random(320, 0, 56);
    test_random(320, 34, 34);
    drain();
    repeat (200) @(posedge clk_i);
    if (n_bad == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/fpsqrt_pkg.sv
sv/fpsqrt_div.sv
sv/fpsqrt_iter.sv
sv/fixed_point_sqrt_newton.sv
tb/tb_top.sv
